@@ hw/rtl/qtbe_pkg.sv @@
// shared types and constants of the quadtree bitmap encoder
package qtbe_pkg;

	localparam int MaxDim     = 256;
	localparam int CoordW     = $clog2(MaxDim);
	localparam int DimW       = CoordW + 1;
	localparam int StackDepth = 32;
	localparam int StackW     = $clog2(StackDepth);
	localparam int LevelW     = StackW + 1;
	localparam int PixAddrW   = 2 * CoordW;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	localparam logic [1:0] SYM_ZERO  = 2'd0;
	localparam logic [1:0] SYM_ONE   = 2'd1;
	localparam logic [1:0] SYM_MIXED = 2'd2;

	localparam logic CFG_HEIGHT = 1'b0;
	localparam logic CFG_WIDTH  = 1'b1;

	typedef struct packed {
		logic [CoordW-1:0] row;
		logic [CoordW-1:0] col;
		logic [DimW-1:0]   h;
		logic [DimW-1:0]   w;
	} region_t;

	// scan request from the sequencer to the pixel scanner
	typedef struct packed {
		logic    start;
		region_t reg_q;
	} scan_req_t;

	typedef struct packed {
		logic       done;
		logic [1:0] sym;
	} scan_rsp_t;

endpackage

@@ hw/rtl/quadtree_bitmap_encoder.sv @@
// top level of the quadtree bitmap encoder
// A load item writes one pixel and restarts the encoder; the next item can be
// taken on the following cycle. A fetch item returns the next symbol of the
// region-quadtree code. The pixel memory is scanned one pixel a cycle, and the
// result of a fetch is given once its whole region has been scanned, and for a
// mixed region only after it has pushed its quadrants. An exhausted fetch has
// its result without a scan. A result register holds the symbol until it is
// taken, and the next item can be accepted on the cycle after that.
module quadtree_bitmap_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       command,
	input  logic [7:0] row,
	input  logic [7:0] col,
	input  logic       pixel,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] symbol,
	output logic       last_symbol,
	output logic       exhausted
);
	import qtbe_pkg::*;

	logic [DimW-1:0] h_q, w_q, clamped;
	logic acc, busy, res_valid, res_last, res_exh;
	logic [1:0] res_sym;
	scan_req_t req;
	scan_rsp_t rsp;

	assign clamped = (cfg_data > 9'(MaxDim)) ? DimW'(MaxDim) : cfg_data;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= '0; w_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_HEIGHT) h_q <= clamped;
			else w_q <= clamped;
		end
	end

	assign in_ready = !busy && !out_valid && !res_valid;
	assign acc = in_valid && in_ready;

	qtbe_scan u_scan (
		.clk, .arst_n,
		.wr_en(acc && command == CMD_LOAD),
		.wr_addr({row, col}),
		.wr_data(pixel),
		.req, .rsp
	);

	qtbe_ctrl u_ctrl (
		.clk, .arst_n,
		.fetch(acc && command == CMD_FETCH),
		.clear(acc && command == CMD_LOAD),
		.img_h(h_q), .img_w(w_q),
		.req, .rsp, .busy,
		.res_valid, .res_sym, .res_last, .res_exh
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0; symbol <= '0; last_symbol <= 1'b0; exhausted <= 1'b0;
		end else if (res_valid) begin
			out_valid <= 1'b1; symbol <= res_sym;
			last_symbol <= res_last; exhausted <= res_exh;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !out_valid) else $error("result overwritten");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready) else $error("accept while busy");
	a_exh_sym: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && exhausted |-> symbol == SYM_ZERO && !last_symbol)
		else $error("bad exhausted result");
`endif

endmodule

@@ hw/rtl/qtbe_scan.sv @@
// pixel memory with a region scanner that classifies a region as 0, 1 or mixed
module qtbe_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [qtbe_pkg::PixAddrW-1:0] wr_addr,
	input  logic                       wr_data,
	input  qtbe_pkg::scan_req_t        req,
	output qtbe_pkg::scan_rsp_t        rsp
);
	import qtbe_pkg::*;

	logic mem [2**PixAddrW];
	logic rd_data_q;
	logic [PixAddrW-1:0] rd_addr;

	logic busy_q, rd_pend_q, first_q, first_val_q, mixed_q, last_s1_q;
	region_t g_q;
	logic [DimW-1:0] y_q, x_q;
	logic at_last;
	logic [CoordW-1:0] ry, cx;

	assign ry = CoordW'(g_q.row + y_q[CoordW-1:0]);
	assign cx = CoordW'(g_q.col + x_q[CoordW-1:0]);
	assign rd_addr = {ry, cx};
	assign at_last = (y_q == g_q.h - 1'b1) && (x_q == g_q.w - 1'b1);

	// pixel store, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// walk the region row by row, comparing each pixel against the first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rd_pend_q   <= 1'b0;
			last_s1_q   <= 1'b0;
			first_q     <= 1'b0;
			first_val_q <= 1'b0;
			mixed_q     <= 1'b0;
			g_q         <= '0;
			y_q         <= '0;
			x_q         <= '0;
			rsp         <= '0;
		end else begin
			rsp.done <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				g_q     <= req.reg_q;
				y_q     <= '0;
				x_q     <= '0;
				first_q <= 1'b1;
				mixed_q <= 1'b0;
				rd_pend_q <= 1'b0;
				last_s1_q <= 1'b0;
			end else if (busy_q) begin
				rd_pend_q <= !last_s1_q || !rd_pend_q ? !last_s1_q : 1'b0;
				if (!last_s1_q) begin
					last_s1_q <= at_last;
					if (x_q == g_q.w - 1'b1) begin
						x_q <= '0;
						y_q <= y_q + 1'b1;
					end else begin
						x_q <= x_q + 1'b1;
					end
				end
				if (rd_pend_q) begin
					first_q <= 1'b0;
					if (first_q) begin
						first_val_q <= rd_data_q;
					end else if (rd_data_q != first_val_q) begin
						mixed_q <= 1'b1;
					end
				end
				// last read has landed
				if (last_s1_q && rd_pend_q) begin
					busy_q   <= 1'b0;
					rsp.done <= 1'b1;
					if (mixed_q || (!first_q && rd_data_q != first_val_q)) begin
						rsp.sym <= SYM_MIXED;
					end else if (first_q) begin
						rsp.sym <= rd_data_q ? SYM_ONE : SYM_ZERO;
					end else begin
						rsp.sym <= first_val_q ? SYM_ONE : SYM_ZERO;
					end
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> !busy_q) else $error("scan done while busy");
	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done) else $error("scan done held");
	a_sym_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (rsp.sym == SYM_ZERO || rsp.sym == SYM_ONE || rsp.sym == SYM_MIXED))
		else $error("bad symbol");
`endif

endmodule

@@ hw/rtl/qtbe_ctrl.sv @@
// region stack memory and fetch sequencer
module qtbe_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fetch,
	input  logic                        clear,
	input  logic [qtbe_pkg::DimW-1:0]   img_h,
	input  logic [qtbe_pkg::DimW-1:0]   img_w,
	output qtbe_pkg::scan_req_t         req,
	input  qtbe_pkg::scan_rsp_t         rsp,
	output logic                        busy,
	output logic                        res_valid,
	output logic [1:0]                  res_sym,
	output logic                        res_last,
	output logic                        res_exh
);
	import qtbe_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_PUSH = 3'd3;

	// encoder phase codes
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_RUN  = 2'd1;
	localparam logic [1:0] PH_DONE = 2'd2;

	region_t stk [StackDepth];
	region_t rd_q;
	logic [2:0] st_q;
	logic [LevelW-1:0] lvl_q;
	logic [1:0] phase_q;
	logic [1:0] push_q;
	region_t g_q;
	logic [DimW-1:0] top, bot, lft, rgt;
	region_t child;
	logic push_ok;

	assign bot = g_q.h >> 1;
	assign top = g_q.h - bot;
	assign rgt = g_q.w >> 1;
	assign lft = g_q.w - rgt;

	// quadrants in push order: bottom-right first, top-left last
	always_comb begin
		child.row = g_q.row;
		child.col = g_q.col;
		child.h   = top;
		child.w   = lft;
		case (push_q)
			2'd0: begin
				child.row = CoordW'(g_q.row + top[CoordW-1:0]);
				child.col = CoordW'(g_q.col + lft[CoordW-1:0]);
				child.h = bot; child.w = rgt;
			end
			2'd1: begin
				child.row = CoordW'(g_q.row + top[CoordW-1:0]);
				child.h = bot;
			end
			2'd2: begin
				child.col = CoordW'(g_q.col + lft[CoordW-1:0]);
				child.w = rgt;
			end
			default: ;
		endcase
	end
	assign push_ok = child.h != '0 && child.w != '0 && lvl_q < LevelW'(StackDepth);

	always_ff @(posedge clk) begin
		if (st_q == ST_PUSH && push_ok) begin
			stk[lvl_q[StackW-1:0]] <= child;
		end
		rd_q <= stk[StackW'(lvl_q - 1'b1)];
	end

	assign busy = st_q != ST_IDLE;

	// one fetch: pop (or start), scan, push quadrants if mixed, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; lvl_q <= '0; phase_q <= PH_IDLE; push_q <= '0;
			req <= '0; res_valid <= 1'b0; res_sym <= '0; res_last <= 1'b0;
			res_exh <= 1'b0; g_q <= '0;
		end else begin
			req.start <= 1'b0;
			res_valid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (clear) begin
						lvl_q <= '0; phase_q <= PH_IDLE;
					end else if (fetch) begin
						if (phase_q == PH_IDLE && img_h != '0 && img_w != '0) begin
							phase_q <= PH_RUN;
							g_q <= '{row: '0, col: '0, h: img_h, w: img_w};
							lvl_q <= '0;
							req.start <= 1'b1;
							req.reg_q <= '{row: '0, col: '0, h: img_h, w: img_w};
							st_q <= ST_SCAN;
						end else if (phase_q == PH_RUN && lvl_q != '0) begin
							lvl_q <= lvl_q - 1'b1;
							st_q <= ST_READ;
						end else begin
							phase_q <= PH_DONE;
							res_valid <= 1'b1; res_sym <= SYM_ZERO;
							res_last <= 1'b0; res_exh <= 1'b1;
						end
					end
				end
				ST_READ: begin
					g_q <= rd_q;
					req.start <= 1'b1;
					req.reg_q <= rd_q;
					st_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (rsp.done) begin
						res_sym <= rsp.sym;
						res_exh <= 1'b0;
						push_q <= '0;
						if (rsp.sym == SYM_MIXED) begin
							st_q <= ST_PUSH;
						end else begin
							res_valid <= 1'b1;
							res_last <= lvl_q == '0;
							if (lvl_q == '0) phase_q <= PH_DONE;
							st_q <= ST_IDLE;
						end
					end
				end
				ST_PUSH: begin
					if (push_ok) lvl_q <= lvl_q + 1'b1;
					push_q <= push_q + 1'b1;
					if (push_q == 2'd3) begin
						res_valid <= 1'b1;
						res_last <= (lvl_q + LevelW'(push_ok)) == '0;
						if ((lvl_q + LevelW'(push_ok)) == '0) phase_q <= PH_DONE;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_lvl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= LevelW'(StackDepth)) else $error("stack overrun");
	a_res_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> st_q == ST_IDLE) else $error("result while busy");
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> st_q == ST_SCAN) else $error("scan start out of place");
`endif

endmodule
